@@ rtl/core/rcpw_pkg.sv @@
// Shared types and constants for the rotate/convert pixel writer.
// No dependencies; every other rtl/core file refers to it by scoped names.
`timescale 1ns / 1ps

package rcpw_pkg;

  localparam int unsigned CNT_W  = 10;  // column/row counter width
  localparam int unsigned DIM_W  = 11;  // frame dimension width
  localparam int unsigned ADDR_W = 22;  // destination byte address width
  localparam int unsigned DATA_W = 24;  // converted pixel width
  localparam int unsigned PIX_W  = 32;  // source pixel width
  localparam int unsigned IDX_W  = 4;   // config register index width
  localparam int unsigned CFGD_W = 16;  // config write data width
  localparam int unsigned BCNT_W = 2;   // byte count width

  // Config register indexes
  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;
  localparam logic [IDX_W-1:0] REG_ROTATION      = 4'd2;
  localparam logic [IDX_W-1:0] REG_FORMAT_MODE   = 4'd3;
  localparam logic [IDX_W-1:0] REG_X_START       = 4'd4;
  localparam logic [IDX_W-1:0] REG_X_END         = 4'd5;
  localparam logic [IDX_W-1:0] REG_Y_START       = 4'd6;
  localparam logic [IDX_W-1:0] REG_Y_END         = 4'd7;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  localparam logic [BCNT_W-1:0] BCNT_16 = 2'd2;
  localparam logic [BCNT_W-1:0] BCNT_24 = 2'd3;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [1:0] {
    FMT_COPY16    = 2'd0,
    FMT_565_TO_24 = 2'd1,
    FMT_32_TO_24  = 2'd2
  } fmt_e;

  // Active configuration, frame size already clamped
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    rot_e             rotation;
    logic [1:0]       format_mode;
    logic [CNT_W-1:0] x_start;
    logic [CNT_W-1:0] x_end;
    logic [CNT_W-1:0] y_start;
    logic [CNT_W-1:0] y_end;
  } cfg_t;

endpackage

@@ rtl/core/rcpw_cfg.sv @@
// Configuration register file with frame size clamping.
// Depends on rcpw_pkg.
`timescale 1ns / 1ps

module rcpw_cfg #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcpw_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [rcpw_pkg::CFGD_W-1:0]   cfg_data_i,
  output rcpw_pkg::cfg_t                cfg_o
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic [rcpw_pkg::DIM_W-1:0] width_q, height_q;
  logic [1:0]                 rot_q, fmt_q;
  logic [rcpw_pkg::CNT_W-1:0] xs_q, xe_q, ys_q, ye_q;
  logic [rcpw_pkg::DIM_W-1:0] wr_val;

  assign cfg_ready_o = 1'b1;
  assign wr_val      = cfg_data_i[rcpw_pkg::DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rcpw_pkg::DIM_RESET;
      height_q <= rcpw_pkg::DIM_RESET;
      rot_q    <= '0;
      fmt_q    <= '0;
      xs_q     <= '0;
      xe_q     <= '0;
      ys_q     <= '0;
      ye_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcpw_pkg::REG_SCREEN_WIDTH:  width_q  <= wr_val;
        rcpw_pkg::REG_SCREEN_HEIGHT: height_q <= wr_val;
        rcpw_pkg::REG_ROTATION:      rot_q    <= wr_val[1:0];
        rcpw_pkg::REG_FORMAT_MODE:   fmt_q    <= wr_val[1:0];
        rcpw_pkg::REG_X_START:       xs_q     <= wr_val[rcpw_pkg::CNT_W-1:0];
        rcpw_pkg::REG_X_END:         xe_q     <= wr_val[rcpw_pkg::CNT_W-1:0];
        rcpw_pkg::REG_Y_START:       ys_q     <= wr_val[rcpw_pkg::CNT_W-1:0];
        rcpw_pkg::REG_Y_END:         ye_q     <= wr_val[rcpw_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to 1..MAX
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width = rcpw_pkg::DIM_W'(1);
    end else if ({2'b00, width_q} > MaxW) begin
      cfg_o.width = MaxW[rcpw_pkg::DIM_W-1:0];
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = rcpw_pkg::DIM_W'(1);
    end else if ({2'b00, height_q} > MaxH) begin
      cfg_o.height = MaxH[rcpw_pkg::DIM_W-1:0];
    end else begin
      cfg_o.height = height_q;
    end
    cfg_o.rotation    = rcpw_pkg::rot_e'(rot_q);
    cfg_o.format_mode = fmt_q;
    cfg_o.x_start     = xs_q;
    cfg_o.x_end       = xe_q;
    cfg_o.y_start     = ys_q;
    cfg_o.y_end       = ye_q;
  end

endmodule

@@ rtl/core/rcpw_pos.sv @@
// Region position counters and the input register stage.
// Depends on rcpw_pkg.
`timescale 1ns / 1ps

module rcpw_pos (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        accept_i,
  input  logic [rcpw_pkg::PIX_W-1:0]  pixel_i,
  input  logic                        first_i,
  input  rcpw_pkg::cfg_t              cfg_i,
  output logic [rcpw_pkg::PIX_W-1:0]  pixel_o,
  output logic [rcpw_pkg::CNT_W-1:0]  x_o,
  output logic [rcpw_pkg::CNT_W-1:0]  y_o,
  output logic                        last_o
);

  logic [rcpw_pkg::CNT_W-1:0] col_q, col_d, row_q, row_d, x, y;
  logic [rcpw_pkg::PIX_W-1:0] pixel_q;
  logic [rcpw_pkg::CNT_W-1:0] x_q, y_q;
  logic                       last_q, xl, yl;

  always_comb begin
    x     = first_i ? cfg_i.x_start : col_q;
    y     = first_i ? cfg_i.y_start : row_q;
    xl    = (x == cfg_i.x_end);
    yl    = (y == cfg_i.y_end);
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (xl) begin
        col_d = cfg_i.x_start;
        row_d = yl ? cfg_i.y_start : y + 1'b1;
      end else begin
        col_d = x + 1'b1;
        row_d = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q <= pixel_i;
      x_q     <= x;
      y_q     <= y;
      last_q  <= xl && yl;
    end
  end

  assign pixel_o = pixel_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign last_o  = last_q;

endmodule

@@ rtl/core/rcpw_xform.sv @@
// Rotated index multiply, pixel format conversion and byte address scaling.
// Two register stages; depends on rcpw_pkg.
`timescale 1ns / 1ps

module rcpw_xform (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  rcpw_pkg::cfg_t                cfg_i,
  input  logic [rcpw_pkg::PIX_W-1:0]    pixel_i,
  input  logic [rcpw_pkg::CNT_W-1:0]    x_i,
  input  logic [rcpw_pkg::CNT_W-1:0]    y_i,
  input  logic                          last_i,
  output logic [rcpw_pkg::ADDR_W-1:0]   addr_o,
  output logic [rcpw_pkg::DATA_W-1:0]   data_o,
  output logic [rcpw_pkg::BCNT_W-1:0]   count_o,
  output logic                          last_o
);

  localparam int unsigned AW = rcpw_pkg::ADDR_W;

  logic [AW-1:0] hm1y, wm1x, mul_a, mul_b, mul_c, idx_d, idx_q;
  logic [rcpw_pkg::DATA_W-1:0] data_d, data2_q, data3_q;
  logic [rcpw_pkg::BCNT_W-1:0] count_d, count2_q, count3_q;
  logic                        last2_q, last3_q;
  logic [AW-1:0]               addr_d, addr_q;

  // Stage 2: index = a*b + c, wrapping modulo 2^22
  always_comb begin
    hm1y = AW'(cfg_i.height) - AW'(y_i) - AW'(1);
    wm1x = AW'(cfg_i.width) - AW'(x_i) - AW'(1);
    case (cfg_i.rotation)
      rcpw_pkg::ROT_90: begin
        mul_a = AW'(x_i);
        mul_b = AW'(cfg_i.height);
        mul_c = hm1y;
      end
      rcpw_pkg::ROT_180: begin
        mul_a = hm1y;
        mul_b = AW'(cfg_i.width);
        mul_c = wm1x;
      end
      rcpw_pkg::ROT_270: begin
        mul_a = wm1x;
        mul_b = AW'(cfg_i.height);
        mul_c = AW'(y_i);
      end
      default: begin
        mul_a = AW'(y_i);
        mul_b = AW'(cfg_i.width);
        mul_c = AW'(x_i);
      end
    endcase
    idx_d = mul_a * mul_b + mul_c;
  end

  always_comb begin
    case (cfg_i.format_mode) inside
      rcpw_pkg::FMT_565_TO_24: begin
        data_d  = {pixel_i[10:5], 2'b00, pixel_i[15:11], 3'b000, pixel_i[4:0], 3'b000};
        count_d = rcpw_pkg::BCNT_24;
      end
      rcpw_pkg::FMT_32_TO_24: begin
        data_d  = {pixel_i[15:8], pixel_i[23:16], pixel_i[7:0]};
        count_d = rcpw_pkg::BCNT_24;
      end
      default: begin
        data_d  = {8'h00, pixel_i[15:0]};
        count_d = rcpw_pkg::BCNT_16;
      end
    endcase
  end

  // Stage 3: scale index by bytes per pixel
  always_comb begin
    if (count2_q == rcpw_pkg::BCNT_24) begin
      addr_d = idx_q + {idx_q[AW-2:0], 1'b0};
    end else begin
      addr_d = {idx_q[AW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q    <= idx_d;
      data2_q  <= data_d;
      count2_q <= count_d;
      last2_q  <= last_i;
      addr_q   <= addr_d;
      data3_q  <= data2_q;
      count3_q <= count2_q;
      last3_q  <= last2_q;
    end
  end

  assign addr_o  = addr_q;
  assign data_o  = data3_q;
  assign count_o = count3_q;
  assign last_o  = last3_q;

endmodule

@@ rtl/core/rotate_convert_pixel_writer_top.sv @@
// An input transfer loads stage 1; the result then passes stages 2 and 3 and is valid on m_axis.
// Throughput is 1 pixel/cycle, set by the index multiply stage and the address scale stage,
// each one register deep; the pipeline advances as a whole when the output is free.
// Reset: config returns to W = H = 1024 with all other registers zero, the column and
// row counters clear to zero, and the pipeline empties. Depends on rcpw_pkg, rcpw_cfg,
// rcpw_pos and rcpw_xform.
`timescale 1ns / 1ps

module rotate_convert_pixel_writer_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcpw_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [rcpw_pkg::CFGD_W-1:0]   cfg_data_i,   // [10:0] register value
  // Source pixel stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i, // [31:0] src_pixel
  input  logic                          s_axis_tuser_i, // [0] region_first
  // Destination write stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [21:0] dest_byte_addr, [45:22] dest_data, [47:46] dest_byte_count
  output logic [47:0]                   m_axis_tdata_o,
  output logic                          m_axis_tlast_o  // region_last
);

  rcpw_pkg::cfg_t cfg;

  logic                        en, accept;
  logic                        v1_q, v2_q, v3_q;
  logic [rcpw_pkg::PIX_W-1:0]  pix1;
  logic [rcpw_pkg::CNT_W-1:0]  x1, y1;
  logic                        last1;
  logic [rcpw_pkg::ADDR_W-1:0] addr;
  logic [rcpw_pkg::DATA_W-1:0] data;
  logic [rcpw_pkg::BCNT_W-1:0] count;
  logic                        last;

  // Advance every stage together whenever the output register is empty or drains.
  assign en              = !v3_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  rcpw_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage 1: pick the pixel position and step the counters on each transfer.
  rcpw_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .accept_i (accept),
    .pixel_i  (s_axis_tdata_i),
    .first_i  (s_axis_tuser_i),
    .cfg_i    (cfg),
    .pixel_o  (pix1),
    .x_o      (x1),
    .y_o      (y1),
    .last_o   (last1)
  );

  // Stages 2 and 3: rotated index, format conversion, byte address.
  rcpw_xform u_xform (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg),
    .pixel_i (pix1),
    .x_i     (x1),
    .y_i     (y1),
    .last_i  (last1),
    .addr_o  (addr),
    .data_o  (data),
    .count_o (count),
    .last_o  (last)
  );

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {count, data, addr};
  assign m_axis_tlast_o  = last;

endmodule

@@ verif/dest_write_checker.sv @@
// Scoreboard for the rotate/convert pixel writer: tracks register writes and pixel
// transfers, computes each destination write and compares it with the output stream.
// Depends on rcpw_pkg.
`timescale 1ns / 1ps

module dest_write_checker
  import rcpw_pkg::*;
#(
  parameter int unsigned MAX_W = 1024,
  parameter int unsigned MAX_H = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [CFGD_W-1:0] cfg_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [31:0]       s_tdata_i,   // [31:0] src_pixel
  input  logic              s_tuser_i,   // [0] region_first
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [47:0]       m_tdata_i,   // [21:0] addr, [45:22] data, [47:46] byte count
  input  logic              m_tlast_i,   // region_last
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  localparam int unsigned MAX_PRINT = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [BCNT_W-1:0] count;
    logic              last;
  } dest_write_t;

  logic [DIM_W-1:0] width_q, height_q;
  rot_e             rot_q;
  logic [1:0]       fmt_q;
  logic [CNT_W-1:0] x_start_q, x_end_q, y_start_q, y_end_q;
  logic [CNT_W-1:0] col_q, row_q;

  dest_write_t      dest_writes_q[$];
  int unsigned      fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_PRINT)
      $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic dest_write_t rotated_write(input logic [31:0] pix,
                                                input logic [CNT_W-1:0] x,
                                                input logic [CNT_W-1:0] y);
    dest_write_t r;
    logic [31:0] w, h, xe, ye, idx, prod;
    w  = (width_q == '0) ? 32'd1 : (width_q > MAX_W) ? 32'(MAX_W) : 32'(width_q);
    h  = (height_q == '0) ? 32'd1 : (height_q > MAX_H) ? 32'(MAX_H) : 32'(height_q);
    xe = 32'(x);
    ye = 32'(y);
    case (fmt_q)
      FMT_565_TO_24: begin
        r.data  = {pix[10:5], 2'b00, pix[15:11], 3'b000, pix[4:0], 3'b000};
        r.count = BCNT_24;
      end
      FMT_32_TO_24: begin
        r.data  = {pix[15:8], pix[23:16], pix[7:0]};
        r.count = BCNT_24;
      end
      default: begin
        r.data  = {8'h00, pix[15:0]};
        r.count = BCNT_16;
      end
    endcase
    // Index arithmetic wraps freely; only the low address bits survive.
    case (rot_q)
      ROT_90:  idx = xe * h + (h - 32'd1 - ye);
      ROT_180: idx = (h - 32'd1 - ye) * w + (w - 32'd1 - xe);
      ROT_270: idx = (w - 32'd1 - xe) * h + ye;
      default: idx = ye * w + xe;
    endcase
    prod   = idx * 32'(r.count);
    r.addr = prod[ADDR_W-1:0];
    r.last = (x == x_end_q) && (y == y_end_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dest_write_t want, got;
    logic [CNT_W-1:0] x, y;
    if (!rst_ni) begin
      width_q   = DIM_RESET;
      height_q  = DIM_RESET;
      rot_q     = ROT_0;
      fmt_q     = FMT_COPY16;
      x_start_q = '0;
      x_end_q   = '0;
      y_start_q = '0;
      y_end_q   = '0;
      col_q     = '0;
      row_q     = '0;
      dest_writes_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SCREEN_WIDTH:  width_q   = cfg_data_i[DIM_W-1:0];
          REG_SCREEN_HEIGHT: height_q  = cfg_data_i[DIM_W-1:0];
          REG_ROTATION:      rot_q     = rot_e'(cfg_data_i[1:0]);
          REG_FORMAT_MODE:   fmt_q     = cfg_data_i[1:0];
          REG_X_START:       x_start_q = cfg_data_i[CNT_W-1:0];
          REG_X_END:         x_end_q   = cfg_data_i[CNT_W-1:0];
          REG_Y_START:       y_start_q = cfg_data_i[CNT_W-1:0];
          REG_Y_END:         y_end_q   = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end

      // Retire before accepting, so a stray result is never matched to a fresh pixel.
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tdata_i[21:0], m_tdata_i[45:22], m_tdata_i[47:46], m_tlast_i};
        if (dest_writes_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata_i[31:0], '0);
        end else begin
          want = dest_writes_q.pop_front();
          if (got.addr != want.addr)
            report_mismatch("dest_byte_addr", 32'(got.addr), 32'(want.addr));
          if (got.data != want.data)
            report_mismatch("dest_data", 32'(got.data), 32'(want.data));
          if (got.count != want.count)
            report_mismatch("dest_byte_count", 32'(got.count), 32'(want.count));
          if (got.last != want.last)
            report_mismatch("region_last", 32'(got.last), 32'(want.last));
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i) begin
          col_q = x_start_q;
          row_q = y_start_q;
        end
        x = col_q;
        y = row_q;
        dest_writes_q.push_back(rotated_write(s_tdata_i, x, y));
        if (x == x_end_q) begin
          col_q = x_start_q;
          row_q = (y == y_end_q) ? y_start_q : y + 1'b1;
        end else begin
          col_q = x + 1'b1;
        end
      end

      pending_o <= dest_writes_q.size();
    end
  end

endmodule

@@ verif/rotate_convert_pixel_writer_top_tb.sv @@
// Top-level bench for rotate_convert_pixel_writer_top: drives register writes and
// pixel traffic, throttles the output, and reports the verdict.
// Depends on rcpw_pkg, the RTL under rtl/core and verif/dest_write_checker.sv.
`timescale 1ns / 1ps

module rotate_convert_pixel_writer_top_tb;
  import rcpw_pkg::*;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned MAX_H        = 1024;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned DRAIN_CYCLES = 12;   // pipeline is 3 deep; leave slack
  localparam int unsigned HOLD_CYCLES  = 300;  // long output hold-off
  localparam int unsigned PHASES       = 16;
  localparam int unsigned PHASE_ITEMS  = 52;
  localparam realtime     TIMEOUT      = 2ms;

  // Codes the package does not name
  localparam logic [IDX_W-1:0] REG_UNUSED = 4'd15;
  localparam logic [1:0]       FMT_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFGD_W-1:0] cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;   // [31:0] src_pixel
  logic              s_tuser = 1'b0; // [0] region_first
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [47:0]       m_tdata;        // [21:0] addr, [45:22] data, [47:46] byte count
  logic              m_tlast;        // region_last

  int unsigned pending;
  int unsigned fail_count;

  // Idle and stall rates in percent, changed per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_request  = 1'b0;

  rotate_convert_pixel_writer_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  dest_write_checker #(
    .MAX_W (MAX_W),
    .MAX_H (MAX_H)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run
  initial begin
    #(TIMEOUT);
    $display("rotate_convert_pixel_writer_top test failed");
    $finish;
  end

  // Output side: stall at the phase rate; on request hold ready low for a long
  // stretch so the pipeline fills and back-pressures the pixel input.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Issue one register write; valid stays high so writes can go back to back.
  // The caller drops valid once the batch is done.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // Bits above the 11-bit value are junk; the block must ignore them.
    cfg_data  <= {5'($urandom), val};
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program the whole register set. Narrow fields may carry junk in the unused bits.
  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [DIM_W-1:0] rot, input logic [DIM_W-1:0] fmt,
                           input logic [DIM_W-1:0] xs, input logic [DIM_W-1:0] xe,
                           input logic [DIM_W-1:0] ys, input logic [DIM_W-1:0] ye);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ROTATION, rot);
    write_reg(REG_FORMAT_MODE, fmt);
    write_reg(REG_X_START, xs);
    write_reg(REG_X_END, xe);
    write_reg(REG_Y_START, ys);
    write_reg(REG_Y_END, ye);
    cfg_valid <= 1'b0;
  endtask

  // Offer one pixel, idling first at the phase rate; return at the transfer edge.
  task automatic send_pixel(input logic [31:0] pix, input logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, then wait for every outstanding result plus pipeline slack.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly small frames; sometimes zero, the maximum, or oversized values to be clamped
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'(MAX_W);
      2:       return '1;
      3:       return DIM_W'($urandom_range(1025, 2047));
      default: return DIM_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Mostly low positions with a short span; sometimes anywhere, giving end-before-start wraps
  function automatic logic [CNT_W-1:0] pick_start();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CNT_W'($urandom);
      default: return CNT_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin : stimulus
    logic [CNT_W-1:0] xs, xe, ys, ye;
    logic [8:0]       junk_rot, junk_fmt;
    logic             junk_xs, junk_xe, junk_ys, junk_ye;
    logic             first;
    int unsigned      region_pixels, pos;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- Directed part, no idling ---
    // Nothing programmed and no region_first: counting starts at column 0, row 0,
    // and the one-pixel region ends on every pixel.
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    wait_idle();

    // RGB565 expansion at ninety degrees on a small frame; single color channels first
    set_frame(11'd5, 11'd4, 11'(ROT_90), 11'(FMT_565_TO_24), 11'd1, 11'd3, 11'd2, 11'd3);
    send_pixel(32'h0000_F800, 1'b1);
    send_pixel(32'h0000_07E0, 1'b0);
    send_pixel(32'h0000_001F, 1'b0);
    send_pixel(32'h0000_FFFF, 1'b0);
    send_pixel(32'hAAAA_5555, 1'b0);
    send_pixel(32'h1234_5678, 1'b0);
    wait_idle();

    // 32-bit to 24-bit at one eighty; width 0 and height 2047 get clamped, the region
    // ends before it starts in both directions, so the counters wrap through 1023 to 0.
    set_frame(11'd0, 11'd2047, 11'(ROT_180), 11'(FMT_32_TO_24),
              11'd1022, 11'd1, 11'd1023, 11'd0);
    send_pixel(32'h00FF_0000, 1'b1);
    send_pixel(32'h0000_FF00, 1'b0);
    send_pixel(32'h0000_00FF, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h8080_8080, 1'b0);
    send_pixel(32'h7F7F_7F7F, 1'b0);
    send_pixel(32'hDEAD_BEEF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    wait_idle();

    // Unused format code behaves as the copy mode; two seventy; a single-pixel region at
    // the far corner, far outside a one-row frame; region_first again mid-run.
    set_frame(11'd1024, 11'd1, 11'(ROT_270), 11'(FMT_UNUSED),
              11'd1023, 11'd1023, 11'd1023, 11'd1023);
    send_pixel(32'hCAFE_F00D, 1'b1);
    send_pixel(32'h0001_8001, 1'b1);
    send_pixel(32'h5A5A_A5A5, 1'b0);
    wait_idle();

    // A write to an index with no register must change nothing.
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;

    // --- Random part: one register set per phase, raster runs with region_first ---
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase

      xs = pick_start();
      ys = pick_start();
      // Short spans keep region_last frequent; now and then the end is anywhere.
      xe = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom) : xs + CNT_W'($urandom_range(0, 6));
      ye = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom) : ys + CNT_W'($urandom_range(0, 4));
      junk_rot = ($urandom_range(0, 3) == 0) ? 9'($urandom) : '0;
      junk_fmt = ($urandom_range(0, 3) == 0) ? 9'($urandom) : '0;
      {junk_xs, junk_xe, junk_ys, junk_ye} = 4'($urandom);

      set_frame(pick_dim(), pick_dim(),
                {junk_rot, 2'($urandom_range(0, 3))}, {junk_fmt, 2'($urandom_range(0, 3))},
                {junk_xs, xs}, {junk_xe, xe}, {junk_ys, ys}, {junk_ye, ye});

      region_pixels = (int'(CNT_W'(xe - xs)) + 1) * (int'(CNT_W'(ye - ys)) + 1);

      // Block the output early in an unthrottled phase while pixels keep coming.
      if (phase == 4) hold_request = 1'b1;

      pos = 0;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        first = (pos == 0);
        // Occasionally drop or add a region_first to break the raster
        if ($urandom_range(0, 19) == 0) first = ~first;
        send_pixel($urandom, first);
        pos = (pos + 1) % region_pixels;
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("rotate_convert_pixel_writer_top test passed");
    end else begin
      $display("rotate_convert_pixel_writer_top test failed");
    end
    $finish;
  end

endmodule
